### src/edsch_pkg.sv
// Package for the elevator disk scheduler: command and result word types,
// status and function codes, select-unit handshake structs.
// No dependencies.
package edsch_pkg;

    // Default sizes
    localparam int TABLE_DEPTH_DEF   = 16;
    localparam int CYLINDER_BITS_DEF = 10;

    // Function codes of a command word
    localparam logic FUNC_SUBMIT   = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // Arm direction
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_ACCEPTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_SERVED   = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    // Command word
    typedef struct packed {
        logic       func;
        logic [7:0] request_id;
        logic [9:0] cylinder;
        logic [7:0] track;
        logic [7:0] record;
    } cmd_word_t;

    // Result word
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] served_id;
        logic [9:0] served_cylinder;
        logic [7:0] served_track;
        logic [7:0] served_record;
        logic       arm_direction;
        logic [4:0] pending_count;
    } res_word_t;

    // Sequencer to select unit
    typedef struct packed {
        logic clear;   // start of a scan: drop all bests
        logic load;    // a table entry is on the read data bus
    } sel_ctrl_t;

    // Select unit to sequencer
    typedef struct packed {
        logic found;   // a candidate exists
        logic flip;    // candidate lies against the arm direction
    } sel_stat_t;

endpackage

### src/elevator_disk_scheduler.sv
// Top level of the elevator (SCAN) disk scheduler: sequencer, head state,
// request table and select unit. Depends on edsch_pkg, edsch_table, edsch_select.
//
//  channel   | ports                 | handshake
//  ----------+-----------------------+----------------------------------------
//  command   | start, busy, cmd      | word taken when start && !busy
//  result    | done, result          | word valid for the one cycle done is high
//
// Submit and dispatch on an empty table: result in the cycle after the command.
// Dispatch with N pending: N table reads for the scan, the drain and choose
// states to settle the pick, one shift step per entry behind the served one
// for the removal, then a finish state, all through the single table read port.
// Reset clears the count, head position and direction; table contents need
// no clearing. The receiver cannot stall; a new command may be taken in the
// cycle its predecessor's result is shown.
module elevator_disk_scheduler #(
    parameter int TABLE_DEPTH   = edsch_pkg::TABLE_DEPTH_DEF,
    parameter int CYLINDER_BITS = edsch_pkg::CYLINDER_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  edsch_pkg::cmd_word_t cmd,
    output logic                 done,
    output edsch_pkg::res_word_t result
);
    import edsch_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = CYLINDER_BITS + 24;

    typedef struct packed {
        logic [7:0]               id;
        logic [CYLINDER_BITS-1:0] cyl;
        logic [7:0]               trk;
        logic [7:0]               rec;
    } entry_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_CHOOSE = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CYLINDER_BITS-1:0] head_cyl_reg, head_cyl_next;
    logic [7:0]               head_rec_reg, head_rec_next;
    logic                     dir_reg, dir_next;
    logic [IW-1:0]            ptr_reg, ptr_next;
    logic                     scan_vld_reg, scan_vld_next;
    logic [IW-1:0]            scan_idx_reg, scan_idx_next;
    logic                     sh_vld_reg, sh_vld_next;
    logic [IW-1:0]            sh_addr_reg, sh_addr_next;
    logic                     done_reg, done_next;
    res_word_t                result_reg, result_next;
    entry_t                   chosen_reg, chosen_next;

    logic          accept;
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    entry_t        new_ent;
    sel_ctrl_t     sel_ctrl;
    sel_stat_t     sel_stat;
    logic [IW-1:0] choice_idx;
    logic [EW-1:0] choice_data;
    logic [CYLINDER_BITS+9:0] cyl_in_wide;
    logic [CYLINDER_BITS+9:0] cyl_out_wide;
    logic [CW+4:0]            pc_wide;
    logic [CW-1:0]            count_dec;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Field width fitting
    assign cyl_in_wide  = {{CYLINDER_BITS{1'b0}}, cmd.cylinder};
    assign cyl_out_wide = {10'd0, chosen_reg.cyl};
    assign count_dec    = count_reg - CW'(1);

    always_comb
    begin
        new_ent.id  = cmd.request_id;
        new_ent.cyl = cyl_in_wide[CYLINDER_BITS-1:0];
        new_ent.trk = cmd.track;
        new_ent.rec = cmd.record;
    end

    // Table port muxing: submit writes at the tail, shift writes one below
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[IW-1:0];
        wdata = new_ent;
        if (sh_vld_reg)
        begin
            we    = 1'b1;
            waddr = sh_addr_reg;
            wdata = rdata;
        end
        else if (accept && (cmd.func == FUNC_SUBMIT) && (count_reg < CW'(TABLE_DEPTH)))
        begin
            we = 1'b1;
        end
        raddr = (state_reg == S_SHIFT) ? (ptr_reg + IW'(1)) : ptr_reg;
    end

    edsch_table #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (EW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sel_ctrl.clear = accept && (cmd.func == FUNC_DISPATCH);
    assign sel_ctrl.load  = scan_vld_reg;

    edsch_select #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .CYLINDER_BITS (CYLINDER_BITS)
    ) u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (sel_ctrl),
        .idx         (scan_idx_reg),
        .data        (rdata),
        .head_cyl    (head_cyl_reg),
        .head_rec    (head_rec_reg),
        .dir         (dir_reg),
        .choice_idx  (choice_idx),
        .choice_data (choice_data),
        .stat        (sel_stat)
    );

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_cyl_next = head_cyl_reg;
        head_rec_next = head_rec_reg;
        dir_next      = dir_reg;
        ptr_next      = ptr_reg;
        scan_vld_next = 1'b0;
        scan_idx_next = scan_idx_reg;
        sh_vld_next   = 1'b0;
        sh_addr_next  = sh_addr_reg;
        chosen_next   = chosen_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        pc_wide       = {5'd0, count_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next                 = '0;
                    result_next.arm_direction   = dir_reg;
                    if (cmd.func == FUNC_SUBMIT)
                    begin
                        done_next = 1'b1;
                        if (count_reg < CW'(TABLE_DEPTH))
                        begin
                            count_next         = count_reg + CW'(1);
                            pc_wide            = {5'd0, count_next};
                            result_next.status = STAT_ACCEPTED;
                        end
                        else
                        begin
                            result_next.status = STAT_FULL;
                        end
                        result_next.pending_count = pc_wide[4:0];
                    end
                    else if (count_reg == '0)
                    begin
                        done_next                 = 1'b1;
                        result_next.status        = STAT_EMPTY;
                        result_next.pending_count = pc_wide[4:0];
                    end
                    else
                    begin
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            // Stream every pending entry through the select unit
            S_SCAN:
            begin
                scan_vld_next = 1'b1;
                scan_idx_next = ptr_reg;
                ptr_next      = ptr_reg + IW'(1);
                if ((CW'(ptr_reg) + CW'(1)) == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_CHOOSE;
            end

            // Take the pick, move the head, set up the removal shift
            S_CHOOSE:
            begin
                if (!sel_stat.found)
                begin
                    done_next                 = 1'b1;
                    result_next               = '0;
                    result_next.status        = STAT_EMPTY;
                    result_next.arm_direction = dir_reg ^ sel_stat.flip;
                    result_next.pending_count = pc_wide[4:0];
                    dir_next                  = dir_reg ^ sel_stat.flip;
                    state_next                = S_IDLE;
                end
                else
                begin
                    chosen_next   = entry_t'(choice_data);
                    head_cyl_next = chosen_next.cyl;
                    head_rec_next = chosen_next.rec;
                    dir_next      = dir_reg ^ sel_stat.flip;
                    ptr_next      = choice_idx;
                    if ((CW'(choice_idx) + CW'(1)) == count_reg)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
            end

            // Read entry ptr+1, written to ptr in the following cycle
            S_SHIFT:
            begin
                sh_vld_next  = 1'b1;
                sh_addr_next = ptr_reg;
                ptr_next     = ptr_reg + IW'(1);
                if ((CW'(ptr_reg) + CW'(2)) == count_reg)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                count_next                  = count_dec;
                pc_wide                     = {5'd0, count_dec};
                done_next                   = 1'b1;
                result_next.status          = STAT_SERVED;
                result_next.served_id       = chosen_reg.id;
                result_next.served_cylinder = cyl_out_wide[9:0];
                result_next.served_track    = chosen_reg.trk;
                result_next.served_record   = chosen_reg.rec;
                result_next.arm_direction   = dir_reg;
                result_next.pending_count   = pc_wide[4:0];
                state_next                  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and head state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_cyl_reg <= '0;
            head_rec_reg <= '0;
            dir_reg      <= DIR_UP;
            scan_vld_reg <= 1'b0;
            sh_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_cyl_reg <= head_cyl_next;
            head_rec_reg <= head_rec_next;
            dir_reg      <= dir_next;
            scan_vld_reg <= scan_vld_next;
            sh_vld_reg   <= sh_vld_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        scan_idx_reg <= scan_idx_next;
        sh_addr_reg  <= sh_addr_next;
        chosen_reg   <= chosen_next;
        result_reg   <= result_next;
    end

endmodule

### src/edsch_table.sv
// Request table storage: one write port, one read port, registered read.
// No dependencies.
module edsch_table #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 34
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/edsch_select.sv
// Running-best unit: tracks same-cylinder, nearest-up and nearest-down
// candidates over a scan of the table and picks the next request.
// Depends on edsch_pkg.
module edsch_select #(
    parameter int TABLE_DEPTH   = 16,
    parameter int CYLINDER_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  edsch_pkg::sel_ctrl_t             ctrl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   idx,
    input  logic [CYLINDER_BITS+23:0]        data,
    input  logic [CYLINDER_BITS-1:0]         head_cyl,
    input  logic [7:0]                       head_rec,
    input  logic                             dir,
    output logic [$clog2(TABLE_DEPTH)-1:0]   choice_idx,
    output logic [CYLINDER_BITS+23:0]        choice_data,
    output edsch_pkg::sel_stat_t             stat
);
    import edsch_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    typedef struct packed {
        logic [7:0]               id;
        logic [CYLINDER_BITS-1:0] cyl;
        logic [7:0]               trk;
        logic [7:0]               rec;
    } entry_t;

    entry_t ent;
    entry_t same_ent_reg, up_ent_reg, dn_ent_reg;
    logic [IW-1:0] same_idx_reg, up_idx_reg, dn_idx_reg;
    logic [7:0]    same_dist_reg;
    logic          same_found_reg, up_found_reg, dn_found_reg;
    logic [7:0]    rec_dist;
    logic          take_same, take_up, take_dn;

    assign ent = entry_t'(data);

    // Record distance and candidate tests; strict compares keep the oldest
    always_comb
    begin
        rec_dist  = (ent.rec >= head_rec) ? (ent.rec - head_rec) : (head_rec - ent.rec);
        take_same = ctrl.load && (ent.cyl == head_cyl)
                    && (!same_found_reg || (rec_dist < same_dist_reg));
        take_up   = ctrl.load && (ent.cyl > head_cyl)
                    && (!up_found_reg || (ent.cyl < up_ent_reg.cyl));
        take_dn   = ctrl.load && (ent.cyl < head_cyl)
                    && (!dn_found_reg || (ent.cyl > dn_ent_reg.cyl));
    end

    // Found flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            same_found_reg <= 1'b0;
            up_found_reg   <= 1'b0;
            dn_found_reg   <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            same_found_reg <= 1'b0;
            up_found_reg   <= 1'b0;
            dn_found_reg   <= 1'b0;
        end
        else
        begin
            if (take_same) same_found_reg <= 1'b1;
            if (take_up)   up_found_reg   <= 1'b1;
            if (take_dn)   dn_found_reg   <= 1'b1;
        end
    end

    // Candidate payloads
    always_ff @(posedge clk)
    begin
        if (take_same)
        begin
            same_ent_reg  <= ent;
            same_idx_reg  <= idx;
            same_dist_reg <= rec_dist;
        end
        if (take_up)
        begin
            up_ent_reg <= ent;
            up_idx_reg <= idx;
        end
        if (take_dn)
        begin
            dn_ent_reg <= ent;
            dn_idx_reg <= idx;
        end
    end

    // Final pick: same cylinder, then ahead, then reverse
    always_comb
    begin
        stat.found  = same_found_reg;
        stat.flip   = 1'b0;
        choice_idx  = same_idx_reg;
        choice_data = same_ent_reg;
        if (!same_found_reg)
        begin
            if (dir == DIR_UP)
            begin
                if (up_found_reg)
                begin
                    stat.found  = 1'b1;
                    choice_idx  = up_idx_reg;
                    choice_data = up_ent_reg;
                end
                else
                begin
                    stat.found  = dn_found_reg;
                    stat.flip   = 1'b1;
                    choice_idx  = dn_idx_reg;
                    choice_data = dn_ent_reg;
                end
            end
            else
            begin
                if (dn_found_reg)
                begin
                    stat.found  = 1'b1;
                    choice_idx  = dn_idx_reg;
                    choice_data = dn_ent_reg;
                end
                else
                begin
                    stat.found  = up_found_reg;
                    stat.flip   = 1'b1;
                    choice_idx  = up_idx_reg;
                    choice_data = up_ent_reg;
                end
            end
        end
    end

endmodule

### verif/edsch_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the elevator disk scheduler testbench: keeps its own copy of the
// pending-request table, head position and arm direction, and predicts each result word.
// Depends on edsch_pkg.
package edsch_tb_pkg;

    import edsch_pkg::*;

    localparam int REQ_SLOTS = TABLE_DEPTH_DEF;

    typedef struct {
        logic [7:0] id;
        logic [9:0] cyl;
        logic [7:0] trk;
        logic [7:0] rec;
    } pending_req_t;

    class arm_schedule_tracker;

        pending_req_t req_list[$];
        logic [9:0]   head_cyl;
        logic [7:0]   head_rec;
        logic         arm_dir;
        res_word_t    due_results[$];
        int unsigned  fail_count;

        function new();
            head_cyl   = '0;
            head_rec   = '0;
            arm_dir    = DIR_UP;
            fail_count = 0;
        endfunction

        // Nearest cylinder strictly past the head in the given direction, oldest on ties
        function int nearest_toward(logic dir);
            int pick;
            pick = -1;
            foreach (req_list[i])
            begin
                if (dir == DIR_UP && req_list[i].cyl > head_cyl)
                begin
                    if (pick < 0 || req_list[i].cyl < req_list[pick].cyl)
                        pick = i;
                end
                else if (dir == DIR_DOWN && req_list[i].cyl < head_cyl)
                begin
                    if (pick < 0 || req_list[i].cyl > req_list[pick].cyl)
                        pick = i;
                end
            end
            return pick;
        endfunction

        // Accepted command word: update the shadow state, queue the expected result
        function void note_command(cmd_word_t c);
            res_word_t    w;
            pending_req_t e;
            int           pick;
            int           rec_gap;
            int           best_dist;
            w = '0;
            if (c.func == FUNC_SUBMIT)
            begin
                if (req_list.size() >= REQ_SLOTS)
                    w.status = STAT_FULL;
                else
                begin
                    e.id  = c.request_id;
                    e.cyl = c.cylinder;
                    e.trk = c.track;
                    e.rec = c.record;
                    req_list.push_back(e);
                    w.status = STAT_ACCEPTED;
                end
            end
            else if (req_list.size() == 0)
                w.status = STAT_EMPTY;
            else
            begin
                // same cylinder first, least record distance
                pick      = -1;
                best_dist = 0;
                foreach (req_list[i])
                begin
                    if (req_list[i].cyl == head_cyl)
                    begin
                        rec_gap = int'(req_list[i].rec) - int'(head_rec);
                        if (rec_gap < 0)
                            rec_gap = -rec_gap;
                        if (pick < 0 || rec_gap < best_dist)
                        begin
                            pick      = i;
                            best_dist = rec_gap;
                        end
                    end
                end
                if (pick < 0)
                    pick = nearest_toward(arm_dir);
                // nothing ahead: the arm turns around
                if (pick < 0)
                begin
                    arm_dir = ~arm_dir;
                    pick    = nearest_toward(arm_dir);
                end
                e        = req_list[pick];
                head_cyl = e.cyl;
                head_rec = e.rec;
                req_list.delete(pick);
                w.status          = STAT_SERVED;
                w.served_id       = e.id;
                w.served_cylinder = e.cyl;
                w.served_track    = e.trk;
                w.served_record   = e.rec;
            end
            w.arm_direction = arm_dir;
            w.pending_count = 5'(req_list.size());
            due_results.push_back(w);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        // Result word from the block: compare with the oldest expectation
        function void check_result(res_word_t got);
            res_word_t want;
            if (due_results.size() == 0)
            begin
                $error("result word with no command outstanding");
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("served_id", want.served_id, got.served_id);
            compare_field("served_cylinder", want.served_cylinder, got.served_cylinder);
            compare_field("served_track", want.served_track, got.served_track);
            compare_field("served_record", want.served_record, got.served_record);
            compare_field("arm_direction", want.arm_direction, got.arm_direction);
            compare_field("pending_count", want.pending_count, got.pending_count);
        endfunction

    endclass

endpackage

### verif/tb_elevator_disk_scheduler.sv
`timescale 1ns / 100ps
// Testbench top for elevator_disk_scheduler: directed SCAN cases, then bursts of
// random submit/dispatch words with random gaps, checked word by word.
// Depends on edsch_pkg, edsch_tb_pkg and the scheduler RTL.
module tb_elevator_disk_scheduler;

    import edsch_pkg::*;
    import edsch_tb_pkg::*;

    localparam int RANDOM_WORDS = 1100;
    localparam int DRAIN_CYCLES = 40;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    cmd_word_t cmd   = '0;
    logic      busy;
    logic      done;
    res_word_t result;

    arm_schedule_tracker sched = new();

    elevator_disk_scheduler DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Monitor: check results first, then note a word taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sched.check_result(result);
            if (start && !busy)
                sched.note_command(cmd);
        end
    end

    // Hold start low for the given gap, then present the word until it is taken
    task automatic send_word(cmd_word_t c, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic submit(logic [7:0] id, logic [9:0] cyl, logic [7:0] trk,
                          logic [7:0] rec, int gap);
        cmd_word_t c;
        c.func       = FUNC_SUBMIT;
        c.request_id = id;
        c.cylinder   = cyl;
        c.track      = trk;
        c.record     = rec;
        send_word(c, gap);
    endtask

    task automatic dispatch(int gap);
        cmd_word_t c;
        c            = cmd_word_t'({$urandom, $urandom});
        c.func       = FUNC_DISPATCH;
        send_word(c, gap);
    endtask

    // Cylinders cluster on a few values so same-cylinder picks and ties happen
    function automatic logic [9:0] pick_cylinder();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 10'($urandom_range(0, 7) * 146);
        else if (r == 5)
            return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        else
            return 10'($urandom_range(0, 1023));
    endfunction

    function automatic logic [7:0] pick_record();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        else if (r < 4)
            return 8'd128;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // style 0: back to back, 1: short gaps, 2: mostly short, a few long
    function automatic int next_gap(int style);
        int r;
        if (style == 0)
            return 0;
        if (style == 1)
            return $urandom_range(0, 2);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(8, 60);
    endfunction

    initial
    begin
        int sent;
        int burst_len;
        int submit_pct;
        int gap_style;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, same-cylinder picks, ties, both reversals
        dispatch(0);
        submit(8'd1, 10'd0, 8'd0, 8'd200, 1);
        submit(8'd2, 10'd0, 8'd17, 8'd100, 0);
        submit(8'd3, 10'd0, 8'd34, 8'd100, 2);
        submit(8'd255, 10'd1023, 8'd255, 8'd255, 0);
        submit(8'd0, 10'd500, 8'd0, 8'd0, 0);
        submit(8'd6, 10'd500, 8'd6, 8'd7, 3);
        dispatch(0);        // closest record on head cylinder
        dispatch(1);        // distance zero
        dispatch(0);        // last one on cylinder 0
        dispatch(0);        // up to 500, older of two wins
        dispatch(2);        // same cylinder again
        dispatch(0);        // up to the top cylinder
        dispatch(0);        // empty again
        submit(8'd7, 10'd10, 8'd1, 8'd50, 0);
        dispatch(0);        // nothing above: turn down
        submit(8'd8, 10'd20, 8'd2, 8'd60, 0);
        dispatch(1);        // nothing below: turn back up
        submit(8'd9, 10'd20, 8'd3, 8'd0, 0);
        submit(8'd10, 10'd20, 8'd4, 8'd120, 0);
        dispatch(0);        // equal record distance both sides, oldest wins
        dispatch(0);

        // Fill past capacity to reach the full status
        for (int i = 0; i < REQ_SLOTS + 2; i++)
            submit(8'($urandom), pick_cylinder(), 8'($urandom), pick_record(), next_gap(2));

        // Random bursts, each with its own submit mix and gap style
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            burst_len = $urandom_range(5, 40);
            case ($urandom_range(0, 2))
                0: submit_pct = 80;
                1: submit_pct = 50;
                default: submit_pct = 25;
            endcase
            gap_style = $urandom_range(0, 2);
            for (int i = 0; i < burst_len; i++)
            begin
                if ($urandom_range(0, 99) < submit_pct)
                    submit(8'($urandom), pick_cylinder(), 8'($urandom), pick_record(),
                           next_gap(gap_style));
                else
                    dispatch(next_gap(gap_style));
                sent++;
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (sched.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sched.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
